>>> src/etpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etpc_pkg
// Shared constants of the edge three-profile counter.
// ----------------------------------------------------------------------------
package etpc_pkg;

   localparam int SET_CAPACITY_DEF = 1024;
   localparam int ID_BITS_DEF      = 32;

   localparam int IN_ID_W   = 32;
   localparam int OP_W      = 2;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   // result field widths
   localparam int COMMON_W  = 11;
   localparam int EDGE_W    = 12;
   localparam int WEDGE_W   = 10;
   localparam int LONE_W    = 32;
   localparam int RSP_RAW_W = COMMON_W + EDGE_W + 2 * WEDGE_W + LONE_W + 2;
   localparam int RSP_DATA_W = ((RSP_RAW_W + 7) / 8) * 8;

   // register addresses
   localparam logic [CSR_AW-1:0] CSR_VERTEX_TOTAL = 3'd0;

   // opcodes
   localparam logic [OP_W-1:0] OP_ADD_SOURCE = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD_TARGET = 2'd1;
   localparam logic [OP_W-1:0] OP_FINISH     = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED     = 2'd3;

endpackage

`default_nettype wire

>>> src/edge_three_profile_counter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edge_three_profile_counter
// Per-edge neighbour set intersection with triangle/wedge/lone counts.
// ----------------------------------------------------------------------------
// Feed the neighbour IDs of an edge's source vertex (tuser = add source) and
// target vertex (tuser = add target), one ID per beat, then a finish beat.
// Duplicates are ignored; an ID arriving at a full set is dropped and flagged.
// The finish beat yields one result beat and clears both sets. Each set lives
// in its own single-port-read RAM of SET_CAPACITY entries, and every search is
// a linear walk of that RAM, one entry per cycle. No new beat is accepted
// until the search of the current beat is through. A finish beat walks the
// source set and, for each source entry, the target set, then waits for the
// result register to drain. While a result waits on rsp_tready, add beats
// for the next edge are still taken. The user must write vertex_total at
// csr address 0 only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module edge_three_profile_counter #(
   parameter int SET_CAPACITY = etpc_pkg::SET_CAPACITY_DEF,
   parameter int ID_BITS      = etpc_pkg::ID_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request stream
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [etpc_pkg::IN_ID_W-1:0]    req_tdata,  // [31:0] neighbour_id
   input  wire logic [etpc_pkg::OP_W-1:0]       req_tuser,  // [1:0] opcode
   // result stream
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [10:0] common_count, [22:11] edge_only_count, [32:23] source_wedges,
   // [42:33] target_wedges, [74:43] lone_count, [75] overflow_flag,
   // [76] saturate_flag, [79:77] zero
   output logic [etpc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // register port
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [etpc_pkg::CSR_AW-1:0]     csr_paddr,
   input  wire logic [etpc_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [etpc_pkg::CSR_DW-1:0]          csr_prdata,
   output logic                                 csr_pready
);
   import etpc_pkg::*;

   localparam int AW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
   localparam int SW = $clog2(SET_CAPACITY + 1);   // holds 0..SET_CAPACITY
   localparam int XW = LONE_W + 2;                 // result arithmetic width

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_FIN_SRC, ST_FIN_KEY, ST_FIN_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [ID_BITS-1:0]    key_ff, key_in;           // ID being searched
   logic                  sel_ff, sel_in;           // 0 source set, 1 target set
   logic                  fin_ff, fin_in;           // scan belongs to a finish
   logic [SW-1:0]         scan_idx_ff, scan_idx_in;
   logic                  rd_vld_ff, rd_vld_in;     // RAM data valid this cycle
   logic [SW-1:0]         outer_ff, outer_in;       // source index on finish
   logic [SW-1:0]         common_ff, common_in;
   logic [SW-1:0]         src_size_ff, src_size_in;
   logic [SW-1:0]         tgt_size_ff, tgt_size_in;
   logic                  dropped_ff, dropped_in;
   logic [LONE_W-1:0]     vtotal_ff, vtotal_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // RAM ports
   logic               src_wr_en, tgt_wr_en, src_rd_en, tgt_rd_en;
   logic [AW-1:0]      src_rd_addr, tgt_rd_addr, wr_addr;
   logic [ID_BITS-1:0] src_rdata, tgt_rdata;

   logic               req_fire, csr_wr, hit, out_free;
   logic [SW-1:0]      scan_size;
   logic [ID_BITS-1:0] scan_rdata, req_id;

   // finish arithmetic
   logic [XW-1:0]       da, db, cc, uni, c1;
   logic [XW-1:0]       edge_x, sw_x, tw_x, lone_x;
   logic                sat;

   etpc_ram #(.WIDTH(ID_BITS), .DEPTH(SET_CAPACITY)) u_src_ram (
      .clock   (clock),
      .wr_en   (src_wr_en),
      .wr_addr (wr_addr),
      .wr_data (key_ff),
      .rd_en   (src_rd_en),
      .rd_addr (src_rd_addr),
      .rd_data (src_rdata)
   );

   etpc_ram #(.WIDTH(ID_BITS), .DEPTH(SET_CAPACITY)) u_tgt_ram (
      .clock   (clock),
      .wr_en   (tgt_wr_en),
      .wr_addr (wr_addr),
      .wr_data (key_ff),
      .rd_en   (tgt_rd_en),
      .rd_addr (tgt_rd_addr),
      .rd_data (tgt_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_id     = ID_BITS'(req_tdata);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_vld_ff || rsp_tready;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr == CSR_VERTEX_TOTAL) ? vtotal_ff : '0;

   assign scan_size  = sel_ff ? tgt_size_ff : src_size_ff;
   assign scan_rdata = sel_ff ? tgt_rdata : src_rdata;
   assign hit        = rd_vld_ff && (scan_rdata == key_ff);

   // counts for the finish beat; c <= min(da, db) so the first two never wrap
   always_comb begin
      da     = XW'(src_size_ff);
      db     = XW'(tgt_size_ff);
      cc     = XW'(common_ff);
      c1     = cc + XW'(1);
      uni    = da + db - cc;
      edge_x = da + db - (cc << 1);
      sat    = 1'b0;
      sw_x   = '0;
      tw_x   = '0;
      lone_x = '0;
      if (da < c1) sat = 1'b1; else sw_x = da - c1;
      if (db < c1) sat = 1'b1; else tw_x = db - c1;
      if (XW'(vtotal_ff) < uni) sat = 1'b1; else lone_x = XW'(vtotal_ff) - uni;
   end

   always_comb begin
      state_in    = state_ff;
      key_in      = key_ff;
      sel_in      = sel_ff;
      fin_in      = fin_ff;
      scan_idx_in = scan_idx_ff;
      rd_vld_in   = 1'b0;
      outer_in    = outer_ff;
      common_in   = common_ff;
      src_size_in = src_size_ff;
      tgt_size_in = tgt_size_ff;
      dropped_in  = dropped_ff;
      vtotal_in   = vtotal_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;

      src_wr_en   = 1'b0;
      tgt_wr_en   = 1'b0;
      src_rd_en   = 1'b0;
      tgt_rd_en   = 1'b0;
      src_rd_addr = scan_idx_ff[AW-1:0];
      tgt_rd_addr = scan_idx_ff[AW-1:0];
      wr_addr     = scan_size[AW-1:0];

      if (csr_wr && csr_paddr == CSR_VERTEX_TOTAL) begin
         vtotal_in = csr_pwdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               scan_idx_in = '0;
               key_in      = req_id;
               case (req_tuser)
                  OP_ADD_SOURCE: begin
                     sel_in   = 1'b0;
                     fin_in   = 1'b0;
                     state_in = ST_SCAN;
                  end
                  OP_ADD_TARGET: begin
                     sel_in   = 1'b1;
                     fin_in   = 1'b0;
                     state_in = ST_SCAN;
                  end
                  OP_FINISH: begin
                     sel_in    = 1'b1;
                     fin_in    = 1'b1;
                     outer_in  = '0;
                     common_in = '0;
                     state_in  = ST_FIN_SRC;
                  end
                  default: ;   // unused opcode is dropped
               endcase
            end
         end

         // linear search of the selected set for key_ff, one read per cycle
         ST_SCAN: begin
            if (hit) begin
               if (fin_ff) begin
                  common_in = common_ff + SW'(1);
                  outer_in  = outer_ff + SW'(1);
                  state_in  = ST_FIN_SRC;
               end else begin
                  state_in  = ST_IDLE;
               end
            end else if (scan_idx_ff == scan_size && !rd_vld_ff) begin
               if (fin_ff) begin
                  outer_in = outer_ff + SW'(1);
                  state_in = ST_FIN_SRC;
               end else begin
                  state_in = ST_IDLE;
                  if (scan_size == SW'(SET_CAPACITY)) begin
                     dropped_in = 1'b1;
                  end else if (sel_ff) begin
                     tgt_wr_en   = 1'b1;
                     tgt_size_in = tgt_size_ff + SW'(1);
                  end else begin
                     src_wr_en   = 1'b1;
                     src_size_in = src_size_ff + SW'(1);
                  end
               end
            end else if (scan_idx_ff < scan_size) begin
               src_rd_en   = !sel_ff;
               tgt_rd_en   = sel_ff;
               rd_vld_in   = 1'b1;
               scan_idx_in = scan_idx_ff + SW'(1);
            end
         end

         ST_FIN_SRC: begin
            if (outer_ff == src_size_ff) begin
               state_in = ST_FIN_DONE;
            end else begin
               src_rd_en   = 1'b1;
               src_rd_addr = outer_ff[AW-1:0];
               state_in    = ST_FIN_KEY;
            end
         end

         ST_FIN_KEY: begin
            key_in      = src_rdata;
            scan_idx_in = '0;
            state_in    = ST_SCAN;
         end

         ST_FIN_DONE: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {3'b000, sat, dropped_ff, lone_x[LONE_W-1:0],
                              tw_x[WEDGE_W-1:0], sw_x[WEDGE_W-1:0],
                              edge_x[EDGE_W-1:0], cc[COMMON_W-1:0]};
               src_size_in = '0;
               tgt_size_in = '0;
               dropped_in  = 1'b0;
               state_in    = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_vld_ff   <= 1'b0;
         src_size_ff <= '0;
         tgt_size_ff <= '0;
         dropped_ff  <= 1'b0;
         vtotal_ff   <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_vld_ff   <= rd_vld_in;
         src_size_ff <= src_size_in;
         tgt_size_ff <= tgt_size_in;
         dropped_ff  <= dropped_in;
         vtotal_ff   <= vtotal_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      key_ff      <= key_in;
      sel_ff      <= sel_in;
      fin_ff      <= fin_in;
      scan_idx_ff <= scan_idx_in;
      outer_ff    <= outer_in;
      common_ff   <= common_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

>>> src/etpc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etpc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module etpc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> src/etpc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etpc_checker
// Port-level checks of the edge three-profile counter.
// ----------------------------------------------------------------------------
module etpc_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [etpc_pkg::OP_W-1:0]       req_tuser,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [etpc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import etpc_pkg::*;

   logic add_beat;
   assign add_beat = req_tvalid && req_tready &&
                     (req_tuser == OP_ADD_SOURCE || req_tuser == OP_ADD_TARGET);

   // held result does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_rst_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // an add never creates a result
   a_add_quiet: assert property (@(posedge clock) disable iff (reset)
      add_beat && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared after an add beat");

   // an add beat always occupies the search before the next beat is taken
   a_add_busy: assert property (@(posedge clock) disable iff (reset)
      add_beat |=> !req_tready)
      else $error("add beat did not occupy the search");

endmodule

bind edge_three_profile_counter etpc_checker u_etpc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
